>>> rtl/ucfc_pkg.sv
package ucfc_pkg;

    localparam int FRAME_BUF_SIZE = 64;
    localparam int POS_W          = $clog2(FRAME_BUF_SIZE);
    localparam int TGT_W          = 9;
    localparam int CNT_W          = (POS_W > TGT_W) ? POS_W : TGT_W;

    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(FRAME_BUF_SIZE - 1);
    localparam logic [POS_W-1:0] PREFIX_LEN = POS_W'(4);
    localparam logic [POS_W-1:0] LEN_POS    = POS_W'(3);

    localparam logic [7:0] BINARY_START = 8'h32;
    localparam logic [7:0] TEXT_START   = 8'h43;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [TGT_W-1:0] LEN_BIAS = TGT_W'(5);

    localparam logic [7:0] CMD_PREFIX [4] = '{8'h43, 8'h4D, 8'h44, 8'h3A};

    typedef enum logic [1:0] {
        FM_IDLE   = 2'd0,
        FM_TEXT   = 2'd1,
        FM_BINARY = 2'd2,
        FM_RADIO  = 2'd3
    } frame_mode_t;

    typedef enum logic [1:0] {
        KIND_BINARY = 2'd0,
        KIND_TEXT   = 2'd1,
        KIND_RADIO  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        VERDICT_CONTINUE = 2'd0,
        VERDICT_COMMAND  = 2'd1,
        VERDICT_RADIO    = 2'd2,
        VERDICT_DROP     = 2'd3
    } verdict_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        kind_t      frame_kind;
        logic       frame_last;
        verdict_t   verdict;
        logic [5:0] frame_len;
    } result_t;

endpackage

>>> rtl/ucfc_item_if.sv
interface ucfc_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/ucfc_result_if.sv
interface ucfc_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic [1:0] frame_kind;
    logic       frame_last;
    logic [1:0] verdict;
    logic [5:0] frame_len;

    modport source (
        output valid, output data_byte, output byte_index, output frame_kind,
        output frame_last, output verdict, output frame_len, input ready
    );
    modport sink (
        input valid, input data_byte, input byte_index, input frame_kind,
        input frame_last, input verdict, input frame_len, output ready
    );
endinterface

>>> rtl/ucfc_frame_tracker.sv
module ucfc_frame_tracker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         rx_byte,
    output ucfc_pkg::result_t  result
);

    logic [ucfc_pkg::POS_W-1:0] pos_reg, pos_next;
    ucfc_pkg::frame_mode_t      mode_reg, mode_next;
    logic [ucfc_pkg::TGT_W-1:0] target_reg, target_next;
    logic                       prefix_reg, prefix_next;

    ucfc_pkg::frame_mode_t      mode_eff;
    logic                       prefix_eff;
    logic [ucfc_pkg::TGT_W-1:0] target_eff;
    logic [ucfc_pkg::POS_W-1:0] count;
    logic [ucfc_pkg::CNT_W-1:0] count_wide;
    logic [ucfc_pkg::CNT_W-1:0] target_wide;
    ucfc_pkg::verdict_t         verdict;
    ucfc_pkg::kind_t            kind;
    logic                       is_eol;

    always_comb
    begin
        // first byte picks the frame kind
        if (pos_reg == '0)
        begin
            priority if (rx_byte == ucfc_pkg::BINARY_START)
                mode_eff = ucfc_pkg::FM_BINARY;
            else if (rx_byte == ucfc_pkg::TEXT_START)
                mode_eff = ucfc_pkg::FM_TEXT;
            else
                mode_eff = ucfc_pkg::FM_RADIO;
        end
        else
        begin
            mode_eff = mode_reg;
        end

        prefix_eff = (pos_reg == '0) ? 1'b1 : prefix_reg;
        if (pos_reg < ucfc_pkg::PREFIX_LEN &&
            rx_byte != ucfc_pkg::CMD_PREFIX[pos_reg[1:0]])
            prefix_eff = 1'b0;

        // count saturates at the buffer limit
        count = (pos_reg < ucfc_pkg::POS_LIMIT) ? pos_reg + 1'b1 : pos_reg;
        count_wide = ucfc_pkg::CNT_W'(count);

        target_eff = target_reg;
        if (mode_eff == ucfc_pkg::FM_BINARY && count == ucfc_pkg::LEN_POS)
            target_eff = {1'b0, rx_byte} + ucfc_pkg::LEN_BIAS;
        target_wide = ucfc_pkg::CNT_W'(target_eff);

        is_eol = (rx_byte == ucfc_pkg::CHAR_LF) || (rx_byte == ucfc_pkg::CHAR_CR);

        verdict = ucfc_pkg::VERDICT_CONTINUE;
        if (mode_eff == ucfc_pkg::FM_BINARY)
        begin
            if (target_eff != '0 && count_wide >= target_wide)
                verdict = ucfc_pkg::VERDICT_COMMAND;
        end
        else if (is_eol)
        begin
            if (mode_eff == ucfc_pkg::FM_TEXT && count >= ucfc_pkg::PREFIX_LEN
                && prefix_eff)
                verdict = ucfc_pkg::VERDICT_COMMAND;
            else
                verdict = ucfc_pkg::VERDICT_RADIO;
        end
        if (verdict == ucfc_pkg::VERDICT_CONTINUE && count >= ucfc_pkg::POS_LIMIT)
            verdict = ucfc_pkg::VERDICT_DROP;

        unique case (mode_eff)
            ucfc_pkg::FM_BINARY: kind = ucfc_pkg::KIND_BINARY;
            ucfc_pkg::FM_TEXT:   kind = ucfc_pkg::KIND_TEXT;
            default:             kind = ucfc_pkg::KIND_RADIO;
        endcase

        result.data_byte  = rx_byte;
        result.byte_index = 6'(pos_reg);
        result.frame_kind = kind;
        result.frame_last = (verdict != ucfc_pkg::VERDICT_CONTINUE);
        result.verdict    = verdict;
        result.frame_len  = (verdict != ucfc_pkg::VERDICT_CONTINUE) ? 6'(count) : 6'd0;

        pos_next    = pos_reg;
        mode_next   = mode_reg;
        target_next = target_reg;
        prefix_next = prefix_reg;
        if (step)
        begin
            if (verdict != ucfc_pkg::VERDICT_CONTINUE)
            begin
                pos_next    = '0;
                mode_next   = ucfc_pkg::FM_IDLE;
                target_next = '0;
                prefix_next = 1'b1;
            end
            else
            begin
                pos_next    = count;
                mode_next   = mode_eff;
                target_next = target_eff;
                prefix_next = prefix_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            mode_reg   <= ucfc_pkg::FM_IDLE;
            target_reg <= '0;
            prefix_reg <= 1'b1;
        end
        else
        begin
            pos_reg    <= pos_next;
            mode_reg   <= mode_next;
            target_reg <= target_next;
            prefix_reg <= prefix_next;
        end
    end

    // a finished frame restarts at position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.frame_last |=> pos_reg == '0)
        else $error("frame end did not clear position");

    // mid-frame the mode is always known
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg != '0 |-> mode_reg != ucfc_pkg::FM_IDLE)
        else $error("open frame without a mode");

    // binary length is only known from the third byte on
    assert property (@(posedge clk) disable iff (!rst_n)
        target_reg != '0 |-> mode_reg == ucfc_pkg::FM_BINARY && pos_reg >= ucfc_pkg::LEN_POS)
        else $error("binary length set outside a binary frame");

endmodule

>>> rtl/usb_command_frame_classifier_core.sv
// each byte passes the input register, then the result register
// throughput: one byte per cycle, sustained while the result side keeps taking transfers
// the classification of each byte is short logic between the input and result registers
// reset: rst_n clears both pipeline valids and the frame tracking state, so the next byte
// opens a new frame
module usb_command_frame_classifier_core (
    input  logic                 clk,
    input  logic                 rst_n,
    ucfc_item_if.sink            item,
    ucfc_result_if.source        result
);

    logic               s1_valid_reg;
    logic [7:0]         s1_byte_reg;
    logic               out_valid_reg;
    ucfc_pkg::result_t  out_reg;
    ucfc_pkg::result_t  classified;
    logic               advance;
    logic               step;

    assign advance    = !out_valid_reg || result.ready;
    assign step       = s1_valid_reg && advance;
    assign item.ready = !s1_valid_reg || advance;

    ucfc_frame_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (s1_byte_reg),
        .result  (classified)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
                s1_valid_reg <= item.valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            s1_byte_reg <= item.rx_byte;
        if (step)
            out_reg <= classified;
    end

    assign result.valid      = out_valid_reg;
    assign result.data_byte  = out_reg.data_byte;
    assign result.byte_index = out_reg.byte_index;
    assign result.frame_kind = out_reg.frame_kind;
    assign result.frame_last = out_reg.frame_last;
    assign result.verdict    = out_reg.verdict;
    assign result.frame_len  = out_reg.frame_len;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.frame_last == (out_reg.verdict != ucfc_pkg::VERDICT_CONTINUE))
        else $error("frame_last and verdict disagree");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_reg.frame_last |-> out_reg.frame_len == 6'd0)
        else $error("length shown on a continuing byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.frame_kind <= ucfc_pkg::KIND_RADIO)
        else $error("invalid frame kind");

    // a byte in the input stage held back only while the result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !step |-> out_valid_reg && !result.ready)
        else $error("input stage stalled without back pressure");

endmodule

>>> bench/tb_top.sv
module tb_top;

    typedef struct packed {
        logic [5:0]            pos;
        ucfc_pkg::frame_mode_t mode;
        logic [8:0]            target;
        logic                  prefix_ok;
    } frame_track_t;

    typedef struct {
        logic [7:0] data;
        bit         hold;
        logic [7:0] gap;
    } rx_item_t;

    localparam frame_track_t TRACK_IDLE =
        '{pos: '0, mode: ucfc_pkg::FM_IDLE, target: '0, prefix_ok: 1'b1};

    logic clk;
    logic rst_n;

    ucfc_item_if   item_ch ();
    ucfc_result_if result_ch ();

    usb_command_frame_classifier_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    rx_item_t          rx_stream_q[$];
    ucfc_pkg::result_t classified_q[$];
    frame_track_t      sched_track;
    frame_track_t      rx_track;
    bit                sched_calm;
    bit                hold_next;
    int unsigned       sched_count;
    int unsigned       frame_no;
    int unsigned       directed_count;
    int unsigned       mismatches;
    ucfc_pkg::result_t want;

    logic [7:0]   gap_left;
    logic [7:0]   stall_left;
    logic [15:0]  phase_left;
    logic         ready_calm;

    function automatic ucfc_pkg::result_t classify_byte(inout frame_track_t st,
                                                        input logic [7:0] b);
        ucfc_pkg::result_t  r;
        int unsigned        count;
        ucfc_pkg::verdict_t v;
        ucfc_pkg::kind_t    k;
        logic [5:0]         idx;
        idx = st.pos;
        v   = ucfc_pkg::VERDICT_CONTINUE;
        if (st.pos == 0)
        begin
            if (b == ucfc_pkg::BINARY_START)
            begin
                st.mode   = ucfc_pkg::FM_BINARY;
                st.target = '0;
            end
            else if (b == ucfc_pkg::TEXT_START)
                st.mode = ucfc_pkg::FM_TEXT;
            else
                st.mode = ucfc_pkg::FM_RADIO;
            st.prefix_ok = 1'b1;
        end
        if (st.pos < 4 && b != ucfc_pkg::CMD_PREFIX[st.pos[1:0]])
            st.prefix_ok = 1'b0;
        count = 32'(st.pos);
        if (count < ucfc_pkg::FRAME_BUF_SIZE - 1)
            count++;
        st.pos = count[5:0];
        case (st.mode)
            ucfc_pkg::FM_BINARY: k = ucfc_pkg::KIND_BINARY;
            ucfc_pkg::FM_TEXT:   k = ucfc_pkg::KIND_TEXT;
            default:             k = ucfc_pkg::KIND_RADIO;
        endcase
        if (st.mode == ucfc_pkg::FM_BINARY)
        begin
            // length byte is the third one; target stays zero until then
            if (count == 3)
                st.target = {1'b0, b} + 9'd5;
            if (st.target != 0 && count >= st.target)
                v = ucfc_pkg::VERDICT_COMMAND;
        end
        else if (b == ucfc_pkg::CHAR_LF || b == ucfc_pkg::CHAR_CR)
        begin
            v = (st.mode == ucfc_pkg::FM_TEXT && count >= 4 && st.prefix_ok)
                ? ucfc_pkg::VERDICT_COMMAND : ucfc_pkg::VERDICT_RADIO;
        end
        if (v == ucfc_pkg::VERDICT_CONTINUE && count >= ucfc_pkg::FRAME_BUF_SIZE - 1)
            v = ucfc_pkg::VERDICT_DROP;
        r.data_byte  = b;
        r.byte_index = idx;
        r.frame_kind = k;
        r.frame_last = (v != ucfc_pkg::VERDICT_CONTINUE);
        r.verdict    = v;
        r.frame_len  = (v != ucfc_pkg::VERDICT_CONTINUE) ? count[5:0] : 6'd0;
        if (v != ucfc_pkg::VERDICT_CONTINUE)
            st = TRACK_IDLE;
        return r;
    endfunction

    function automatic logic [7:0] pick_gap();
        int unsigned r;
        if (sched_calm)
            return 8'd0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 8'd0;
        if (r < 85)
            return 8'($urandom_range(1, 3));
        if (r < 97)
            return 8'($urandom_range(4, 12));
        return 8'($urandom_range(20, 60));
    endfunction

    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == ucfc_pkg::CHAR_LF || b == ucfc_pkg::CHAR_CR);
        return b;
    endfunction

    function automatic logic [7:0] line_end();
        return ($urandom_range(0, 1) == 0) ? ucfc_pkg::CHAR_LF : ucfc_pkg::CHAR_CR;
    endfunction

    // fit is the payload length that puts the terminator in the last buffer slot
    function automatic int unsigned pick_len(input int unsigned fit);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 10);
        if (r < 92)
            return $urandom_range(11, fit);
        if (r < 96)
            return fit;
        return $urandom_range(fit, fit + 3);
    endfunction

    task automatic push_byte(input logic [7:0] b);
        rx_item_t          it;
        ucfc_pkg::result_t unused;
        it.data   = b;
        it.hold   = hold_next;
        it.gap    = pick_gap();
        hold_next = 1'b0;
        rx_stream_q.push_back(it);
        unused = classify_byte(sched_track, b);
        sched_count++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    task automatic gen_frame(input int unsigned fno);
        int unsigned r;
        int unsigned m;
        logic [7:0]  b;
        sched_calm = ((fno / 16) % 3 == 0);
        // close whatever frame noise left open
        while (sched_track.pos != 0)
            push_byte(ucfc_pkg::CHAR_LF);
        hold_next = (fno % 40 == 3);
        r = $urandom_range(0, 99);
        if (r < 20)
        begin
            push_text("CMD:");
            repeat (pick_len(58)) push_byte(body_byte());
            push_byte(line_end());
        end
        else if (r < 35)
        begin
            m = $urandom_range(1, 4);
            for (int i = 0; i < m; i++)
                push_byte(ucfc_pkg::CMD_PREFIX[i]);
            if ($urandom_range(0, 1) == 0)
                push_byte(body_byte());
            repeat (pick_len(61 - m)) push_byte(body_byte());
            push_byte(line_end());
        end
        else if (r < 60)
        begin
            push_byte(ucfc_pkg::BINARY_START);
            push_byte(8'($urandom_range(0, 255)));
            m = $urandom_range(0, 9);
            if (m < 7)
                push_byte(8'($urandom_range(0, 20)));
            else if (m < 9)
                push_byte(8'($urandom_range(21, 57)));
            else
                push_byte(8'($urandom_range(58, 255)));
            while (sched_track.pos != 0)
                push_byte(8'($urandom_range(0, 255)));
        end
        else if (r < 80)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == ucfc_pkg::BINARY_START || b == ucfc_pkg::TEXT_START);
            push_byte(b);
            if (sched_track.pos != 0)
            begin
                repeat (pick_len(61)) push_byte(body_byte());
                push_byte(line_end());
            end
        end
        else if (r < 90)
        begin
            // no terminator: runs into the buffer limit unless the first byte opens a binary frame
            push_byte(body_byte());
            while (sched_track.pos != 0)
                push_byte(body_byte());
        end
        else
        begin
            repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic note_mismatch(input string what, input logic [7:0] exp_v,
                                 input logic [7:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", what, exp_v, act_v);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #12_000_000;
        $display("usb_command_frame_classifier_core regression: fail");
        $finish;
    end

    // byte sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid   <= 1'b0;
            item_ch.rx_byte <= 8'd0;
            gap_left        <= 8'd0;
        end
        else if (!item_ch.valid || item_ch.ready)
        begin
            if (gap_left != 0)
            begin
                item_ch.valid <= 1'b0;
                gap_left      <= gap_left - 8'd1;
            end
            else if (rx_stream_q.size() != 0 &&
                     !(rx_stream_q[0].hold && (item_ch.valid || classified_q.size() != 0)))
            begin
                item_ch.valid   <= 1'b1;
                item_ch.rx_byte <= rx_stream_q[0].data;
                gap_left        <= rx_stream_q[0].gap;
                void'(rx_stream_q.pop_front());
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // result side back-pressure, alternating calm and stalling phases
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= 8'd0;
            phase_left      <= 16'd0;
            ready_calm      <= 1'b0;
        end
        else
        begin
            if (phase_left == 0)
            begin
                ready_calm <= !ready_calm;
                phase_left <= 16'($urandom_range(40, 400));
            end
            else
                phase_left <= phase_left - 16'd1;
            if (stall_left != 0)
            begin
                result_ch.ready <= 1'b0;
                stall_left      <= stall_left - 8'd1;
            end
            else if (!ready_calm && $urandom_range(0, 99) < 35)
            begin
                result_ch.ready <= 1'b0;
                stall_left      <= ($urandom_range(0, 9) == 0) ? 8'($urandom_range(10, 40))
                                                               : 8'($urandom_range(0, 3));
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    // check results first, then queue the classification of the byte taken this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (classified_q.size() == 0)
                    note_mismatch("transfer with nothing pending, data_byte", 8'd0,
                                  result_ch.data_byte);
                else
                begin
                    want = classified_q.pop_front();
                    if (result_ch.data_byte !== want.data_byte)
                        note_mismatch("data_byte", want.data_byte, result_ch.data_byte);
                    if (result_ch.byte_index !== want.byte_index)
                        note_mismatch("byte_index", want.byte_index, result_ch.byte_index);
                    if (result_ch.frame_kind !== want.frame_kind)
                        note_mismatch("frame_kind", want.frame_kind, result_ch.frame_kind);
                    if (result_ch.frame_last !== want.frame_last)
                        note_mismatch("frame_last", want.frame_last, result_ch.frame_last);
                    if (result_ch.verdict !== want.verdict)
                        note_mismatch("verdict", want.verdict, result_ch.verdict);
                    if (result_ch.frame_len !== want.frame_len)
                        note_mismatch("frame_len", want.frame_len, result_ch.frame_len);
                end
            end
            if (item_ch.valid && item_ch.ready)
                classified_q.push_back(classify_byte(rx_track, item_ch.rx_byte));
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        sched_track     = TRACK_IDLE;
        rx_track        = TRACK_IDLE;
        sched_calm      = 1'b0;
        hold_next       = 1'b0;
        sched_count     = 0;
        mismatches      = 0;

        // command line
        push_text("CMD:");
        push_byte(ucfc_pkg::CHAR_LF);
        // short text line goes to radio
        push_text("CM");
        push_byte(ucfc_pkg::CHAR_CR);
        // binary frame of length 5, the line feed inside is payload
        hold_next = 1'b1;
        push_byte(ucfc_pkg::BINARY_START);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(ucfc_pkg::CHAR_LF);
        push_byte(8'hFF);
        push_byte(ucfc_pkg::CHAR_CR);
        // a lone terminator is a one-byte radio frame
        push_byte(ucfc_pkg::CHAR_LF);
        push_text("C");
        push_byte(ucfc_pkg::CHAR_LF);
        // long enough but wrong prefix
        push_text("CMDX");
        push_byte(ucfc_pkg::CHAR_LF);
        directed_count = sched_count;

        frame_no = 0;
        while (sched_count < directed_count + 2000)
        begin
            gen_frame(frame_no);
            frame_no++;
        end

        repeat (12) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        do
            @(posedge clk);
        while (rx_stream_q.size() != 0 || item_ch.valid || classified_q.size() != 0);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("usb_command_frame_classifier_core regression: pass");
        else
            $display("usb_command_frame_classifier_core regression: fail");
        $finish;
    end

endmodule

>>> sim.f
rtl/ucfc_pkg.sv
rtl/ucfc_item_if.sv
rtl/ucfc_result_if.sv
rtl/ucfc_frame_tracker.sv
rtl/usb_command_frame_classifier_core.sv
bench/tb_top.sv
